// ===== rtl/core/fht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Folding hash table package
// Payload types and command and status codes shared by the interfaces and the
// table logic.
// ----------------------------------------------------------------------------
package fht_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned KEY_W      = 31;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned SLOT_OUT_W = 7;

    // Decimal radix and the number of decimal digits in the largest key.
    localparam int unsigned DEC_RADIX  = 10;
    localparam int unsigned KEY_DIGITS = 10;

    typedef logic [CMD_W-1:0]      t_cmd;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [SLOT_OUT_W-1:0] t_slot_out;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_DELETE = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_COLLISION = 3'd1;
    localparam t_status ST_DELETED   = 3'd2;
    localparam t_status ST_FOUND     = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;

endpackage

// ===== rtl/core/fht_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Folding hash table command channel
// Valid/ready channel that carries one table command and its key.
// ----------------------------------------------------------------------------
interface fht_cmd_if;

    logic          valid;
    logic          ready;
    fht_pkg::t_cmd cmd;
    fht_pkg::t_key key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);

endinterface

// ===== rtl/core/fht_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Folding hash table response channel
// Valid/ready channel that carries the status and hash slot of one command.
// ----------------------------------------------------------------------------
interface fht_rsp_if;

    logic               valid;
    logic               ready;
    fht_pkg::t_status   status;
    fht_pkg::t_slot_out slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);

endinterface

// ===== rtl/core/fht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fht_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/fht_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division by a constant
// Two-stage quotient and remainder of an unsigned value by a fixed divisor,
// using a reciprocal multiply followed by a single correction step.
// ----------------------------------------------------------------------------
module fht_cdiv #(
    parameter int unsigned W       = 31,
    parameter int unsigned DIVISOR = 100
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_dividend,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);

    localparam logic [W-1:0] RECIP = W'((64'd1 << W) / DIVISOR);
    localparam logic [W-1:0] DIV_C = W'(DIVISOR);

    logic [2*W-1:0] w_prod;
    logic [W-1:0]   r_x;
    logic [W-1:0]   r_q0;
    logic [W-1:0]   w_mq;
    logic [W-1:0]   w_rem0;

    // The truncated reciprocal product is at most one below the true quotient.
    assign w_prod = (2*W)'(i_dividend) * (2*W)'(RECIP);

    always_ff @(posedge i_clk) begin
        r_x  <= i_dividend;
        r_q0 <= w_prod[2*W-1:W];
    end

    assign w_mq   = r_q0 * DIV_C;
    assign w_rem0 = r_x - w_mq;

    always_comb begin
        if (w_rem0 >= DIV_C) begin
            o_quot = r_q0 + W'(1);
            o_rem  = w_rem0 - DIV_C;
        end else begin
            o_quot = r_q0;
            o_rem  = w_rem0;
        end
    end

endmodule

// ===== rtl/core/folding_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Folding hash table
// Single-entry-per-slot key table addressed by a decimal folding hash.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table once to mark every slot empty, during
// which no command is taken. Each command then folds its key one decimal digit
// group at a time through S_FOLD_MUL and S_FOLD_ACC, up to and including its most
// significant non-zero group (none for a zero key, at most five with two-digit
// groups), the constant divider peeling off each group. The folded sum is reduced
// in S_MOD_DONE when it reaches 10^GROUP_DIGITS, and the slot is reduced modulo
// TABLE_DEPTH in S_IDX when 10^GROUP_DIGITS exceeds TABLE_DEPTH. The entry is read
// in S_READ and written back in S_EXEC for a delete or an insert into an empty slot.
// A response waiting in the output register does not stop the next command from
// being taken, but that command's result waits in S_RESULT until the register is
// free. Code 3 on the command field is dropped without a response.
module folding_hash_table #(
    parameter int unsigned GROUP_DIGITS = 2,
    parameter int unsigned TABLE_DEPTH  = 100
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fht_cmd_if.sink   i_cmd,
    fht_rsp_if.source o_rsp
);

    localparam int unsigned GROUP_MOD = fht_pkg::DEC_RADIX ** GROUP_DIGITS;
    localparam int unsigned NGROUPS   =
        (fht_pkg::KEY_DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
    localparam int unsigned SUM_W     = $clog2(NGROUPS * GROUP_MOD);
    localparam int unsigned SLOT_W    = $clog2(GROUP_MOD);
    localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
    localparam int unsigned KEY_W     = fht_pkg::KEY_W;
    localparam int unsigned ENTRY_W   = KEY_W + 1;
    localparam bit          NEED_IDX_DIV = (GROUP_MOD > TABLE_DEPTH);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_FOLD_MUL = 10'b00_0000_0100,
        S_FOLD_ACC = 10'b00_0000_1000,
        S_MOD_CHK  = 10'b00_0001_0000,
        S_MOD_DONE = 10'b00_0010_0000,
        S_IDX      = 10'b00_0100_0000,
        S_READ     = 10'b00_1000_0000,
        S_EXEC     = 10'b01_0000_0000,
        S_RESULT   = 10'b10_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_clr_addr, n_clr_addr;

    fht_pkg::t_cmd      r_cmd, n_cmd;
    fht_pkg::t_key      r_kin, n_kin;
    fht_pkg::t_key      r_key, n_key;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [IDX_W-1:0]   r_idx, n_idx;
    fht_pkg::t_status   r_pend, n_pend;
    fht_pkg::t_status   r_out_status, n_out_status;
    fht_pkg::t_slot_out r_out_slot, n_out_slot;

    logic [KEY_W-1:0]   w_div_in;
    logic [KEY_W-1:0]   w_div_quot;
    logic [KEY_W-1:0]   w_div_rem;
    logic [IDX_W-1:0]   w_idx_calc;

    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_rd_en;
    logic [ENTRY_W-1:0] w_rd_data;

    logic               w_cmd_xfer;
    logic               w_out_free;
    fht_pkg::t_status   w_status;

    // One divider serves both the digit-group folding and the final reduction
    // of the folded sum.
    assign w_div_in = (r_state == S_FOLD_MUL) ? r_key : KEY_W'(r_sum);

    fht_cdiv #(
        .W       (KEY_W),
        .DIVISOR (GROUP_MOD)
    ) u_group_div (
        .i_clk      (i_clk),
        .i_dividend (w_div_in),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    generate
        if (NEED_IDX_DIV) begin : g_idx_div
            logic [SLOT_W-1:0] w_idx_rem;

            fht_cdiv #(
                .W       (SLOT_W),
                .DIVISOR (TABLE_DEPTH)
            ) u_idx_div (
                .i_clk      (i_clk),
                .i_dividend (r_slot),
                .o_quot     (),
                .o_rem      (w_idx_rem)
            );

            assign w_idx_calc = IDX_W'(w_idx_rem);
        end else begin : g_idx_direct
            assign w_idx_calc = IDX_W'(r_slot);
        end
    endgenerate

    // Each entry holds the occupancy flag above the stored key.
    fht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_idx_calc),
        .o_rd_data (w_rd_data)
    );

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign w_cmd_xfer   = i_cmd.valid && (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || o_rsp.ready;
    assign w_rd_en      = (r_state == S_READ);

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    // Outcome of the command from the entry just read.
    always_comb begin
        case (r_cmd)
            fht_pkg::CMD_INSERT: begin
                w_status = w_rd_data[KEY_W] ? fht_pkg::ST_COLLISION : fht_pkg::ST_INSERTED;
            end
            fht_pkg::CMD_DELETE: begin
                w_status = fht_pkg::ST_DELETED;
            end
            fht_pkg::CMD_SEARCH: begin
                w_status = (w_rd_data[KEY_W] && (w_rd_data[KEY_W-1:0] == r_kin)) ?
                           fht_pkg::ST_FOUND : fht_pkg::ST_NOT_FOUND;
            end
            default: begin
                w_status = fht_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_clr_addr   = r_clr_addr;
        n_cmd        = r_cmd;
        n_kin        = r_kin;
        n_key        = r_key;
        n_sum        = r_sum;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = {1'b0, r_kin};

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = '0;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_cmd_xfer && (i_cmd.cmd inside {fht_pkg::CMD_INSERT,
                                                     fht_pkg::CMD_DELETE,
                                                     fht_pkg::CMD_SEARCH})) begin
                    n_cmd   = i_cmd.cmd;
                    n_kin   = i_cmd.key;
                    n_key   = i_cmd.key;
                    n_sum   = '0;
                    n_state = S_FOLD_MUL;
                end
            end
            S_FOLD_MUL: begin
                if (r_key == '0) begin
                    n_state = S_MOD_CHK;
                end else begin
                    n_state = S_FOLD_ACC;
                end
            end
            S_FOLD_ACC: begin
                n_key   = w_div_quot;
                n_sum   = r_sum + SUM_W'(w_div_rem);
                n_state = S_FOLD_MUL;
            end
            S_MOD_CHK: begin
                if (r_sum < SUM_W'(GROUP_MOD)) begin
                    n_slot  = SLOT_W'(r_sum);
                    n_state = NEED_IDX_DIV ? S_IDX : S_READ;
                end else begin
                    n_state = S_MOD_DONE;
                end
            end
            S_MOD_DONE: begin
                n_slot  = SLOT_W'(w_div_rem);
                n_state = NEED_IDX_DIV ? S_IDX : S_READ;
            end
            S_IDX: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_idx   = w_idx_calc;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_cmd == fht_pkg::CMD_DELETE) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {1'b0, r_kin};
                end else if ((r_cmd == fht_pkg::CMD_INSERT) && !w_rd_data[KEY_W]) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {1'b1, r_kin};
                end
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = w_status;
                    n_out_slot   = fht_pkg::t_slot_out'(r_slot);
                    n_state      = S_IDLE;
                end else begin
                    n_pend  = w_status;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    n_out_slot   = fht_pkg::t_slot_out'(r_slot);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_kin        <= n_kin;
        r_key        <= n_key;
        r_sum        <= n_sum;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

`ifndef SYNTHESIS
    // A new response only appears once a command has been carried out.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_RESULT))
        else $error("response raised outside the execute or result state");

    // Each folding step peels off a digit group that is below the group modulus.
    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD_ACC) |-> (w_div_rem < KEY_W'(GROUP_MOD)))
        else $error("digit group out of range");

    // The remaining key shrinks with every folded group.
    a_key_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD_ACC) |=> (r_key < $past(r_key)))
        else $error("folding made no progress");

    // The hash slot is reduced before the table is addressed.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (32'(r_slot) < GROUP_MOD))
        else $error("hash slot not reduced");

    // The table index stays inside the table.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (32'(r_idx) < TABLE_DEPTH))
        else $error("table index beyond the table");
`endif

endmodule
